// ----- rtl/spmv_pkg.sv -----
// Shared constants, operation codes and inter-stage structs for the sparse matrix-vector unit.
package spmv_pkg;

    // Dense vector store geometry
    localparam int VEC_DEPTH = 1024;
    localparam int VEC_AW    = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;

    // Operation codes carried by an input transaction
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_NZ    = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Item after the vector store read
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
        logic [31:0] y_start;
        logic        row_end;
        logic [31:0] x;
    } t_s1;

    // Finished row, before rounding and clipping
    typedef struct packed {
        logic        empty;
        logic [63:0] acc;
        logic [31:0] y_start;
        logic [15:0] row_idx;
    } t_row;

endpackage

// ----- rtl/spmv_vec_store.sv -----
// Dense vector store: takes input transactions, writes loads and reads x for nonzeros.
module spmv_vec_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_operation,
    input  logic [9:0]          i_vec_index,
    input  logic [31:0]         i_value,
    input  logic [31:0]         i_y_start,
    input  logic                i_row_end,
    output logic                o_valid,
    input  logic                i_ready,
    output spmv_pkg::t_s1       o_s1
);

    logic [31:0]                 mem [spmv_pkg::VEC_DEPTH];
    logic [spmv_pkg::VEC_AW-1:0] addr;
    logic [31:0]                 idx_wide;
    logic                        in_range;
    logic                        fire;

    logic        r_v;
    logic        r_inr;
    logic [31:0] r_rd;
    logic [1:0]  r_op;
    logic [31:0] r_value;
    logic [31:0] r_ys;
    logic        r_last;

    assign idx_wide = {22'd0, i_vec_index};
    assign in_range = idx_wide < 32'(spmv_pkg::VEC_DEPTH);
    assign addr     = spmv_pkg::VEC_AW'(i_vec_index);
    assign o_ready  = !r_v || i_ready;
    assign fire     = i_valid && o_ready;

    // Write loads and read x on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (fire && i_operation == spmv_pkg::OP_LOAD && in_range) begin
            mem[addr] <= i_value;
        end
        if (fire) begin
            r_rd <= mem[addr];
        end
    end

    // Hold the item fields beside the read data
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_inr   <= in_range;
            r_op    <= i_operation;
            r_value <= i_value;
            r_ys    <= i_y_start;
            r_last  <= i_row_end;
        end
    end

    // Drop the unused operation code here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid && (i_operation != spmv_pkg::OP_NONE);
        end
    end

    assign o_valid         = r_v;
    assign o_s1.op         = r_op;
    assign o_s1.value      = r_value;
    assign o_s1.y_start    = r_ys;
    assign o_s1.row_end    = r_last;
    assign o_s1.x          = r_inr ? r_rd : 32'd0;

endmodule

// ----- rtl/spmv_mac.sv -----
// Multiply stage and row accumulator with the row counter and open-row state.
module spmv_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  spmv_pkg::t_s1       i_s1,
    output logic                o_valid,
    input  logic                i_ready,
    output spmv_pkg::t_row      o_row
);

    logic               r2_v;
    logic [1:0]         r2_op;
    logic signed [63:0] r2_prod;
    logic [31:0]        r2_ys;
    logic               r2_last;

    logic               r_open;
    logic signed [63:0] r_acc;
    logic [15:0]        r_cnt;

    logic               r3_v;
    spmv_pkg::t_row     r3_row;

    logic               s3_rdy;
    logic               res;
    logic               s2_go;
    logic signed [63:0] base;
    logic signed [63:0] sum;
    logic signed [63:0] sat_sum;

    assign s3_rdy  = !r3_v || i_ready;
    assign res     = (r2_op == spmv_pkg::OP_EMPTY) || (r2_op == spmv_pkg::OP_NZ && r2_last);
    assign s2_go   = r2_v && (!res || s3_rdy);
    assign o_ready = !r2_v || s2_go;

    // Multiply value by x, one product per cycle while o_ready is high
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r2_op   <= i_s1.op;
            r2_prod <= 64'($signed(i_s1.value)) * 64'($signed(i_s1.x));
            r2_ys   <= i_s1.y_start;
            r2_last <= i_s1.row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (o_ready) begin
            r2_v <= i_valid;
        end
    end

    // Seed from the row's starting y, then add with 64-bit saturation
    always_comb begin
        base = r_open ? r_acc : $signed({{16{r2_ys[31]}}, r2_ys, 16'h0000});
        sum  = base + r2_prod;
        if (base[63] == r2_prod[63] && sum[63] != base[63]) begin
            sat_sum = base[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_sum = sum;
        end
    end

    // Advance row state in transaction order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_acc  <= '0;
            r_cnt  <= '0;
        end else if (s2_go) begin
            case (r2_op)
                spmv_pkg::OP_LOAD: begin
                    r_open <= 1'b0;
                    r_acc  <= '0;
                    r_cnt  <= '0;
                end
                spmv_pkg::OP_NZ: begin
                    if (r2_last) begin
                        r_open <= 1'b0;
                        r_acc  <= '0;
                        r_cnt  <= r_cnt + 16'd1;
                    end else begin
                        r_open <= 1'b1;
                        r_acc  <= sat_sum;
                    end
                end
                spmv_pkg::OP_EMPTY: begin
                    r_open <= 1'b0;
                    r_acc  <= '0;
                    r_cnt  <= r_cnt + 16'd1;
                end
                default: begin
                    r_open <= r_open;
                end
            endcase
        end
    end

    // Capture a finished row
    always_ff @(posedge i_clk) begin
        if (s2_go && res) begin
            r3_row.empty   <= (r2_op == spmv_pkg::OP_EMPTY);
            r3_row.acc     <= sat_sum;
            r3_row.y_start <= r2_ys;
            r3_row.row_idx <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (s3_rdy) begin
            r3_v <= s2_go && res;
        end
    end

    assign o_valid = r3_v;
    assign o_row   = r3_row;

endmodule

// ----- rtl/spmv_out.sv -----
// Result stage: floor shift to Q16.16, clip to 32 bits and hold the output transaction.
module spmv_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  spmv_pkg::t_row      i_row,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_y_value,
    output logic [15:0]         o_row_index,
    output logic                o_saturated
);

    logic        r_v;
    logic [31:0] r_y;
    logic [15:0] r_idx;
    logic        r_sat;

    logic        fits;
    logic [31:0] n_y;
    logic        n_sat;

    assign o_ready = !r_v || i_ready;

    // Bits above the Q16.16 result must all copy its sign bit
    assign fits = (i_row.acc[63:47] == '0) || (i_row.acc[63:47] == '1);

    always_comb begin
        if (i_row.empty) begin
            n_y   = i_row.y_start;
            n_sat = 1'b0;
        end else if (fits) begin
            n_y   = i_row.acc[47:16];
            n_sat = 1'b0;
        end else begin
            n_y   = i_row.acc[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            n_sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_y   <= n_y;
            r_idx <= i_row.row_idx;
            r_sat <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    assign o_valid     = r_v;
    assign o_y_value   = r_y;
    assign o_row_index = r_idx;
    assign o_saturated = r_sat;

endmodule

// ----- rtl/csr_sparse_matrix_vector_multiply_unit.sv -----
// Top level of the CSR sparse matrix times dense vector unit.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    operation, vec_index, value, y_start, row_end
//  out      output     o_out_valid / i_out_ready  y_value, row_index, saturated
//
// One transaction is taken per cycle while o_in_ready is high; a row result
// leaves, after the transaction that finishes it, through the store read,
// multiply, accumulate and clip registers. The accumulator update is the one loop.
// Reset clears the row counter, the open-row state and all stage valids; the
// vector store is not cleared. Each stage moves on when the next has room, so
// a stalled output only blocks input once every stage ahead is full.
module csr_sparse_matrix_vector_multiply_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [9:0]  i_vec_index,
    input  logic [31:0] i_value,
    input  logic [31:0] i_y_start,
    input  logic        i_row_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_y_value,
    output logic [15:0] o_row_index,
    output logic        o_saturated
);

    logic           s1_valid;
    logic           s1_ready;
    spmv_pkg::t_s1  s1;
    logic           row_valid;
    logic           row_ready;
    spmv_pkg::t_row row;

    // Store the vector and fetch x
    spmv_vec_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_operation (i_operation),
        .i_vec_index (i_vec_index),
        .i_value     (i_value),
        .i_y_start   (i_y_start),
        .i_row_end   (i_row_end),
        .o_valid     (s1_valid),
        .i_ready     (s1_ready),
        .o_s1        (s1)
    );

    // Multiply and accumulate rows
    spmv_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_s1    (s1),
        .o_valid (row_valid),
        .i_ready (row_ready),
        .o_row   (row)
    );

    // Round, clip and present the result
    spmv_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (row_valid),
        .o_ready     (row_ready),
        .i_row       (row),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_y_value   (o_y_value),
        .o_row_index (o_row_index),
        .o_saturated (o_saturated)
    );

endmodule
